>>> rtl/tfc_pkg.sv
package tfc_pkg;

	localparam logic [7:0] SYNC_RESET      = 8'hBB;
	localparam logic [7:0] CHECKSUM_OFFSET = 8'd4;
	localparam logic [7:0] MIN_FULL_LENGTH = 8'd24;
	localparam logic [7:0] FIELD_START     = 8'd4;
	localparam logic [7:0] BATTERY_START   = 8'd20;
	localparam logic [7:0] POSITION_MAX    = 8'd255;
	localparam int         NUM_WORDS       = 5;
	localparam logic [2:0] BATTERY_INDEX   = 3'd4;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_BAD_HDR   = 2'd1,
		STATUS_BAD_SUM   = 2'd2,
		STATUS_TOO_SHORT = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CHECK_PENDING  = 2'd0,
		CHECK_MATCH    = 2'd1,
		CHECK_MISMATCH = 2'd2
	} check_t;

endpackage

>>> rtl/tfc_if.sv
interface tfc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_datagram;

	modport source (output valid, output data_byte, output end_of_datagram, input ready);
	modport sink   (input valid, input data_byte, input end_of_datagram, output ready);
endinterface

interface tfc_result_if;
	logic             valid;
	logic             ready;
	tfc_pkg::status_t status;
	logic [31:0]      roll_bits;
	logic [31:0]      pitch_bits;
	logic [31:0]      yaw_bits;
	logic [31:0]      altitude_bits;
	logic [31:0]      battery_word;

	modport source (
		output valid, output status, output roll_bits, output pitch_bits,
		output yaw_bits, output altitude_bits, output battery_word, input ready
	);
	modport sink (
		input valid, input status, input roll_bits, input pitch_bits,
		input yaw_bits, input altitude_bits, input battery_word, output ready
	);
endinterface

>>> rtl/telemetry_frame_checker_top.sv
// Telemetry datagram checker. Takes one datagram word (byte) per cycle and, on the
// word marked end_of_datagram, delivers one report: status (ok, bad header,
// checksum mismatch, too short) and, only when ok, the roll, pitch, yaw and
// altitude float bit patterns and the battery word. Throughput is one word per
// clock while the report side is not stalled; the last word is held in the input
// register and the report is then registered in the output register. The rate
// rests on the combinational update of the byte position and running checksum from
// the input register. The user must write sync_value through cfg_wr_en/cfg_wr_data
// only while no datagram is in flight (not enforced by the block); resets to 0xBB.
module telemetry_frame_checker_top (
	input  logic                clk,
	input  logic                arst_n,
	tfc_byte_if.sink            datagram,
	tfc_result_if.source        report,
	input  logic                cfg_wr_en,
	input  logic [7:0]          cfg_wr_data
);
	import tfc_pkg::*;

	logic        sync_q;
	logic [7:0]  sync_value_q;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        eod_s1;

	logic [7:0]  pos_q;
	logic [7:0]  len_q;
	logic [7:0]  sum_q;
	logic        hdr_good_q;
	check_t      check_q;
	logic [31:0] words_q [NUM_WORDS];

	logic        out_valid_q;
	status_t     status_q;
	logic [31:0] out_words_q [NUM_WORDS];

	logic        out_free;
	logic        advance;
	logic [8:0]  check_at;
	logic [7:0]  pos_nx;
	logic [7:0]  len_nx;
	logic [7:0]  sum_nx;
	logic        hdr_good_nx;
	check_t      check_nx;
	logic [31:0] words_nx [NUM_WORDS];
	logic [2:0]  word_sel;
	logic [1:0]  lane;
	logic        in_fields;
	status_t     status_nx;

	assign out_free       = !out_valid_q || report.ready;
	assign advance        = valid_s1 && (!eod_s1 || out_free);
	assign datagram.ready = !valid_s1 || advance;

	assign sync_q = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_value_q <= SYNC_RESET;
		end else if (cfg_wr_en && sync_q) begin
			sync_value_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (datagram.ready) begin
			valid_s1 <= datagram.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (datagram.ready && datagram.valid) begin
			byte_s1 <= datagram.data_byte;
			eod_s1  <= datagram.end_of_datagram;
		end
	end

	always_comb begin
		check_at    = {1'b0, len_q} + {1'b0, CHECKSUM_OFFSET};
		hdr_good_nx = hdr_good_q;
		len_nx      = len_q;
		sum_nx      = sum_q;
		check_nx    = check_q;
		for (int i = 0; i < NUM_WORDS; i++) begin
			words_nx[i] = words_q[i];
		end

		if ((pos_q == 8'd0 || pos_q == 8'd1) && byte_s1 != sync_value_q) begin
			hdr_good_nx = 1'b0;
		end
		if (pos_q == 8'd3) begin
			len_nx = byte_s1;
		end

		if (pos_q < CHECKSUM_OFFSET) begin
			sum_nx = sum_q + byte_s1;
		end else if (check_q == CHECK_PENDING) begin
			if ({1'b0, pos_q} == check_at) begin
				check_nx = (sum_q == byte_s1) ? CHECK_MATCH : CHECK_MISMATCH;
			end else if ({1'b0, pos_q} < check_at && pos_q < POSITION_MAX) begin
				sum_nx = sum_q + byte_s1;
			end
		end

		in_fields = pos_q >= FIELD_START && pos_q < MIN_FULL_LENGTH;
		if (pos_q < BATTERY_START) begin
			word_sel = pos_q[4:2] - 3'd1;
			lane     = pos_q[1:0];
		end else begin
			word_sel = BATTERY_INDEX;
			lane     = ~pos_q[1:0];
		end
		if (in_fields) begin
			words_nx[word_sel][{lane, 3'b000} +: 8] = byte_s1;
		end

		pos_nx = (pos_q < POSITION_MAX) ? pos_q + 8'd1 : pos_q;

		if (pos_nx < 8'd2) begin
			status_nx = STATUS_TOO_SHORT;
		end else if (!hdr_good_nx) begin
			status_nx = STATUS_BAD_HDR;
		end else if (check_nx == CHECK_PENDING) begin
			status_nx = STATUS_TOO_SHORT;
		end else if (check_nx == CHECK_MISMATCH) begin
			status_nx = STATUS_BAD_SUM;
		end else if (pos_nx < MIN_FULL_LENGTH) begin
			status_nx = STATUS_TOO_SHORT;
		end else begin
			status_nx = STATUS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			len_q      <= '0;
			sum_q      <= '0;
			hdr_good_q <= 1'b1;
			check_q    <= CHECK_PENDING;
		end else if (advance) begin
			if (eod_s1) begin
				pos_q      <= '0;
				len_q      <= '0;
				sum_q      <= '0;
				hdr_good_q <= 1'b1;
				check_q    <= CHECK_PENDING;
			end else begin
				pos_q      <= pos_nx;
				len_q      <= len_nx;
				sum_q      <= sum_nx;
				hdr_good_q <= hdr_good_nx;
				check_q    <= check_nx;
			end
		end
	end

	// Field words need no clear: an ok report implies every byte was rewritten.
	always_ff @(posedge clk) begin
		if (advance) begin
			for (int i = 0; i < NUM_WORDS; i++) begin
				words_q[i] <= words_nx[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && eod_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance && eod_s1) begin
			status_q <= status_nx;
			for (int i = 0; i < NUM_WORDS; i++) begin
				out_words_q[i] <= (status_nx == STATUS_OK) ? words_nx[i] : 32'd0;
			end
		end
	end

	assign report.valid         = out_valid_q;
	assign report.status        = status_q;
	assign report.roll_bits     = out_words_q[0];
	assign report.pitch_bits    = out_words_q[1];
	assign report.yaw_bits      = out_words_q[2];
	assign report.altitude_bits = out_words_q[3];
	assign report.battery_word  = out_words_q[4];

endmodule

>>> tb/telemetry_frame_checker_top_test.sv
module telemetry_frame_checker_top_test;
	import tfc_pkg::*;

	localparam int CYCLE_LIMIT = 400_000;
	localparam int LONG_HOLD   = 250;

	typedef struct packed {
		logic [7:0] b;
		logic       last;
	} dgram_word_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] roll;
		logic [31:0] pitch;
		logic [31:0] yaw;
		logic [31:0] alt;
		logic [31:0] batt;
	} frame_report_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [7:0] cfg_wr_data;

	tfc_byte_if   dg_if ();
	tfc_result_if rpt_if ();

	telemetry_frame_checker_top u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.datagram   (dg_if),
		.report     (rpt_if),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	// frame decoder shadow
	logic [7:0]  sync_byte;
	logic [7:0]  pos;
	logic [7:0]  decl_len;
	logic [7:0]  csum;
	logic        hdr_ok;
	check_t      outcome;
	logic [31:0] words [NUM_WORDS];

	dgram_word_t   word_queue [$];
	frame_report_t reports_due [$];

	int  errors        = 0;
	int  reports_seen  = 0;
	int  bytes_planned = 0;
	int  cycles        = 0;
	int  tx_gap        = 0;
	int  rx_stall      = 0;
	int  hold_left     = 0;
	bit  offering      = 0;
	bit  no_idle       = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic void clear_frame();
		pos      = '0;
		decl_len = '0;
		csum     = '0;
		hdr_ok   = 1'b1;
		outcome  = CHECK_PENDING;
		foreach (words[i]) words[i] = '0;
	endfunction

	function automatic bit feed_byte(input logic [7:0] b, input logic last,
			output frame_report_t r);
		int      p;
		int      chk_at;
		int      count;
		status_t st;
		p = int'(pos);
		if ((p == 0 || p == 1) && b != sync_byte) hdr_ok = 1'b0;
		if (p == 3) decl_len = b;
		chk_at = int'(decl_len) + int'(CHECKSUM_OFFSET);
		if (p < int'(CHECKSUM_OFFSET)) begin
			csum = csum + b;
		end else if (outcome == CHECK_PENDING) begin
			if (p == chk_at) outcome = (csum == b) ? CHECK_MATCH : CHECK_MISMATCH;
			else if (p < chk_at && p < int'(POSITION_MAX)) csum = csum + b;
		end
		if (p >= int'(FIELD_START) && p < int'(BATTERY_START)) begin
			words[(p - 4) >> 2] |= 32'(b) << (((p - 4) & 3) * 8);
		end else if (p >= int'(BATTERY_START) && p < int'(MIN_FULL_LENGTH)) begin
			words[BATTERY_INDEX] |= 32'(b) << ((23 - p) * 8);
		end
		if (pos < POSITION_MAX) pos = pos + 8'd1;
		r = '0;
		if (!last) return 1'b0;
		count = int'(pos);
		if (count < 2) st = STATUS_TOO_SHORT;
		else if (!hdr_ok) st = STATUS_BAD_HDR;
		else if (outcome == CHECK_PENDING) st = STATUS_TOO_SHORT;
		else if (outcome == CHECK_MISMATCH) st = STATUS_BAD_SUM;
		else if (count < int'(MIN_FULL_LENGTH)) st = STATUS_TOO_SHORT;
		else st = STATUS_OK;
		r.status = st;
		if (st == STATUS_OK) begin
			r.roll  = words[0];
			r.pitch = words[1];
			r.yaw   = words[2];
			r.alt   = words[3];
			r.batt  = words[BATTERY_INDEX];
		end
		clear_frame();
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		errors++;
		if (errors <= 40)
			$display("mismatch on %s at report %0d: got %h, want %h",
				what, reports_seen, got, want);
	endtask

	always @(posedge clk or negedge arst_n) begin
		frame_report_t r;
		dgram_word_t   nxt;
		if (!arst_n) begin
			dg_if.valid <= 1'b0;
			offering = 1'b0;
			tx_gap   = 0;
		end else begin
			if (dg_if.valid && dg_if.ready) begin
				if (feed_byte(dg_if.data_byte, dg_if.end_of_datagram, r))
					reports_due.push_back(r);
				offering = 1'b0;
				tx_gap   = no_idle ? 0 : $urandom_range(0, 3);
			end
			if (!offering) begin
				if (tx_gap != 0) begin
					tx_gap--;
				end else if (word_queue.size() != 0) begin
					nxt      = word_queue.pop_front();
					offering = 1'b1;
					dg_if.data_byte       <= nxt.b;
					dg_if.end_of_datagram <= nxt.last;
				end
			end
			dg_if.valid <= offering;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		frame_report_t want;
		if (!arst_n) begin
			rpt_if.ready <= 1'b0;
			rx_stall  = 0;
			hold_left = 0;
		end else begin
			if (rpt_if.valid && rpt_if.ready) begin
				if (reports_due.size() == 0) begin
					report_mismatch("unexpected report status", 32'(rpt_if.status), '0);
				end else begin
					want = reports_due.pop_front();
					if (rpt_if.status !== want.status)
						report_mismatch("status", 32'(rpt_if.status), 32'(want.status));
					if (rpt_if.roll_bits !== want.roll)
						report_mismatch("roll_bits", rpt_if.roll_bits, want.roll);
					if (rpt_if.pitch_bits !== want.pitch)
						report_mismatch("pitch_bits", rpt_if.pitch_bits, want.pitch);
					if (rpt_if.yaw_bits !== want.yaw)
						report_mismatch("yaw_bits", rpt_if.yaw_bits, want.yaw);
					if (rpt_if.altitude_bits !== want.alt)
						report_mismatch("altitude_bits", rpt_if.altitude_bits, want.alt);
					if (rpt_if.battery_word !== want.batt)
						report_mismatch("battery_word", rpt_if.battery_word, want.batt);
				end
				reports_seen++;
				// hold off long enough to back the datagram input up
				if (reports_seen % 20 == 3) hold_left = LONG_HOLD;
				rx_stall = no_idle ? 0 : $urandom_range(0, 3);
			end
			if (hold_left != 0) begin
				hold_left--;
				rpt_if.ready <= 1'b0;
			end else if (rx_stall != 0) begin
				rx_stall--;
				rpt_if.ready <= 1'b0;
			end else begin
				rpt_if.ready <= 1'b1;
			end
		end
	end

	// fill < 0 gives random payload, else every payload word is fill
	function automatic void make_frame(ref logic [7:0] f[$], input int len, input int total,
			input int fill);
		logic [7:0] s;
		f.delete();
		f.push_back(sync_byte);
		f.push_back(sync_byte);
		f.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
		f.push_back(8'(len));
		while (f.size() < total) f.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
		s = '0;
		for (int i = 0; i < len + 4 && i < total; i++) s = s + f[i];
		if (len + 4 < total) f[len + 4] = s;
	endfunction

	function automatic void queue_frame(input logic [7:0] f[$]);
		foreach (f[i]) word_queue.push_back('{b: f[i], last: (i == f.size() - 1)});
		bytes_planned += f.size();
	endfunction

	task automatic random_frames(input int n_bytes);
		logic [7:0] f[$];
		int k;
		int len;
		int total;
		int stop_at;
		stop_at = bytes_planned + n_bytes;
		while (bytes_planned < stop_at) begin
			k = $urandom_range(0, 99);
			if ($urandom_range(0, 39) == 0) len = $urandom_range(200, 255);
			else len = $urandom_range(0, 24);
			total = (len + 5 > 24) ? len + 5 : 24;
			if (total > 256) total = 256;
			total += $urandom_range(0, 3);
			make_frame(f, len, total, -1);
			if (k < 65) begin
			end else if (k < 73) begin
				f[$urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
			end else if (k < 81) begin
				if (len + 4 < total) f[len + 4] ^= 8'($urandom_range(1, 255));
			end else if (k < 88) begin
				f = f[0:$urandom_range(0, (len + 3 < total - 1) ? len + 3 : total - 1)];
			end else if (k < 94) begin
				make_frame(f, $urandom_range(0, 18), 0, -1);
				len = f[3];
				make_frame(f, len, len + 5, -1);
			end else begin
				total = $urandom_range(1, 30);
				f.delete();
				repeat (total) f.push_back(8'($urandom));
				if (total >= 2 && $urandom_range(0, 1)) begin
					f[0] = sync_byte;
					f[1] = sync_byte;
				end
			end
			queue_frame(f);
		end
	endtask

	task automatic drain();
		while (word_queue.size() != 0 || offering || reports_due.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_sync(input logic [7:0] v);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		sync_byte = v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		logic [7:0] f[$];
		arst_n                = 1'b0;
		cfg_wr_en             = 1'b0;
		cfg_wr_data           = '0;
		dg_if.valid           = 1'b0;
		dg_if.data_byte       = '0;
		dg_if.end_of_datagram = 1'b0;
		rpt_if.ready          = 1'b0;
		sync_byte = SYNC_RESET;
		clear_frame();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		make_frame(f, 19, 24, 255); queue_frame(f);
		make_frame(f, 19, 24, 0);   queue_frame(f);
		f = {SYNC_RESET};           queue_frame(f);
		f = {SYNC_RESET, SYNC_RESET}; queue_frame(f);
		make_frame(f, 20, 28, -1); f[0] ^= 8'h01; queue_frame(f);
		make_frame(f, 20, 28, -1); f[1] ^= 8'h80; queue_frame(f);
		make_frame(f, 22, 30, -1); f[26] ^= 8'h5A; queue_frame(f);
		make_frame(f, 30, 40, -1); f = f[0:19]; queue_frame(f);
		make_frame(f, 0, 5, -1);    queue_frame(f);
		make_frame(f, 18, 23, -1);  queue_frame(f);
		make_frame(f, 251, 259, -1); queue_frame(f);
		make_frame(f, 252, 256, -1); queue_frame(f);
		make_frame(f, 255, 258, -1); queue_frame(f);
		drain();

		write_sync(8'h00);
		random_frames(60);
		drain();

		no_idle = 1'b1;
		write_sync(8'hFF);
		random_frames(60);
		drain();

		no_idle = 1'b0;
		write_sync(8'($urandom));
		random_frames(60);
		drain();

		write_sync(SYNC_RESET);
		random_frames(60);
		drain();

		if (errors == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end

endmodule
